// ===== design/amcp_pkg.sv =====
package amcp_pkg;

    localparam int AXIS_W       = 3;
    localparam int MOVE_W       = 16;
    localparam int SPEED_W      = 8;
    localparam int POS_W        = 10;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_POS_REGS = 6;
    localparam int POS_LIMIT    = 511;
    localparam int TDATA_W      = 40;

    localparam logic [STATUS_W-1:0] ST_CMD       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END       = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [AXIS_W-1:0]   axis;
        logic [MOVE_W-1:0]   rel;
        logic [SPEED_W-1:0]  speed;
        logic [STATUS_W-1:0] status;
        logic                last;
    } evt_t;

    // returns {hit, axis code}
    function automatic logic [AXIS_W:0] axis_lookup(input logic [7:0] b);
        logic [AXIS_W:0] r;
        unique case (b)
            8'h42:   r = {1'b1, 3'd0};
            8'h43:   r = {1'b1, 3'd1};
            8'h45:   r = {1'b1, 3'd2};
            8'h50:   r = {1'b1, 3'd3};
            8'h52:   r = {1'b1, 3'd4};
            8'h54:   r = {1'b1, 3'd5};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/amcp_parser.sv =====
module amcp_parser #(
    parameter int NUM_AXES = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [7:0]             in_data,
    input  logic                   in_last,
    output logic                   in_ready,
    input  logic                   evt_ready,
    output logic                   evt_valid,
    output amcp_pkg::evt_t         evt
);

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    typedef enum logic [2:0] {
        PH_AXIS, PH_SIGN, PH_MFIRST, PH_MDIG, PH_SPD, PH_DONE
    } ph_t;

    ph_t                              phase_reg, phase_next;
    logic [amcp_pkg::AXIS_W-1:0]      axis_reg, axis_next;
    logic                             neg_reg, neg_next;
    logic [amcp_pkg::MOVE_W-1:0]      move_reg, move_next;
    logic [amcp_pkg::SPEED_W-1:0]     speed_reg, speed_next;
    logic                             discard_reg, discard_next;
    logic                             evt_valid_reg;
    amcp_pkg::evt_t                   evt_reg, evt_next;
    logic [amcp_pkg::MOVE_W-1:0]      last_move_reg [NUM_AXES];
    logic [amcp_pkg::SPEED_W-1:0]     last_speed_reg [NUM_AXES];

    logic                             accept;
    logic                             active;
    logic                             sep;
    logic                             is_dig;
    logic [3:0]                       digit;
    logic [amcp_pkg::AXIS_W:0]        lookup;
    logic                             emit_cmd;
    logic                             has_result;
    logic [amcp_pkg::MOVE_W-1:0]      rel;
    logic [IDX_W-1:0]                 mem_idx;

    assign in_ready  = !evt_valid_reg || evt_ready;
    assign accept    = in_valid && in_ready;
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    assign active = !discard_reg && (phase_reg != PH_DONE);
    assign sep    = (in_data == amcp_pkg::CH_SEMI) || (in_data == amcp_pkg::CH_NUL);
    assign is_dig = (in_data >= amcp_pkg::CH_ZERO) && (in_data <= amcp_pkg::CH_NINE);
    assign digit  = 4'(in_data - amcp_pkg::CH_ZERO);
    assign lookup = amcp_pkg::axis_lookup(in_data);
    assign rel    = neg_next ? 16'(16'd0 - move_next) : move_next;
    assign mem_idx = axis_next[IDX_W-1:0];

    always_comb begin
        phase_next   = phase_reg;
        axis_next    = axis_reg;
        neg_next     = neg_reg;
        move_next    = move_reg;
        speed_next   = speed_reg;
        discard_next = discard_reg;
        emit_cmd     = 1'b0;
        has_result   = 1'b0;
        evt_next     = '0;

        if (active) begin
            if (sep) begin
                if (phase_reg == PH_SPD) begin
                    emit_cmd = 1'b1;
                end else if (phase_reg != PH_AXIS) begin
                    discard_next = 1'b1;
                end
                phase_next = (in_data == amcp_pkg::CH_NUL) ? PH_DONE : PH_AXIS;
            end else begin
                unique case (phase_reg)
                    PH_AXIS: begin
                        if (lookup[amcp_pkg::AXIS_W] &&
                            int'(lookup[amcp_pkg::AXIS_W-1:0]) < NUM_AXES) begin
                            axis_next  = lookup[amcp_pkg::AXIS_W-1:0];
                            neg_next   = 1'b0;
                            move_next  = '0;
                            speed_next = '0;
                            phase_next = PH_SIGN;
                        end else begin
                            discard_next = 1'b1;
                        end
                    end
                    PH_SIGN: begin
                        if (in_data == amcp_pkg::CH_PLUS || in_data == amcp_pkg::CH_MINUS) begin
                            neg_next   = (in_data == amcp_pkg::CH_MINUS);
                            phase_next = PH_MFIRST;
                        end else begin
                            discard_next = 1'b1;
                        end
                    end
                    PH_MFIRST, PH_MDIG: begin
                        if (is_dig) begin
                            move_next  = 16'(move_reg * 16'd10 + 16'(digit));
                            phase_next = PH_MDIG;
                        end else if (in_data == amcp_pkg::CH_COLON && phase_reg == PH_MDIG) begin
                            phase_next = PH_SPD;
                        end else begin
                            discard_next = 1'b1;
                        end
                    end
                    PH_SPD: begin
                        if (is_dig) begin
                            speed_next = 8'(speed_reg * 8'd10 + 8'(digit));
                        end else begin
                            discard_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (in_last && !emit_cmd && !discard_next) begin
            if (phase_next == PH_SPD) begin
                emit_cmd = 1'b1;
            end else if (phase_next != PH_AXIS && phase_next != PH_DONE) begin
                discard_next = 1'b1;
            end
        end

        has_result = emit_cmd || in_last;
        if (emit_cmd) begin
            evt_next.axis   = axis_next;
            evt_next.rel    = rel;
            evt_next.speed  = speed_next;
            evt_next.status = amcp_pkg::ST_CMD;
            evt_next.last   = in_last;
        end else begin
            evt_next.status = discard_next ? amcp_pkg::ST_MALFORMED : amcp_pkg::ST_END;
            evt_next.last   = 1'b1;
        end

        if (in_last) begin
            phase_next   = PH_AXIS;
            discard_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_AXIS;
            axis_reg      <= '0;
            neg_reg       <= 1'b0;
            move_reg      <= '0;
            speed_reg     <= '0;
            discard_reg   <= 1'b0;
            evt_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                last_move_reg[i]  <= '0;
                last_speed_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                axis_reg    <= axis_next;
                neg_reg     <= neg_next;
                move_reg    <= move_next;
                speed_reg   <= speed_next;
                discard_reg <= discard_next;
                if (emit_cmd) begin
                    last_move_reg[mem_idx]  <= rel;
                    last_speed_reg[mem_idx] <= speed_next;
                end
            end
            if (accept && has_result) begin
                evt_valid_reg <= 1'b1;
            end else if (evt_ready) begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && has_result) begin
            evt_reg <= evt_next;
        end
    end

endmodule

// ===== design/amcp_out_stage.sv =====
module amcp_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [amcp_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [amcp_pkg::POS_W-1:0]          cfg_wr_data,
    input  logic                                evt_valid,
    input  amcp_pkg::evt_t                      evt,
    output logic                                evt_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [amcp_pkg::TDATA_W-1:0]        m_data,
    output logic [amcp_pkg::STATUS_W-1:0]       m_user,
    output logic                                m_last
);

    localparam int SUM_W = amcp_pkg::MOVE_W + 1;
    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(amcp_pkg::POS_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_LO = SUM_W'(-amcp_pkg::POS_LIMIT);
    localparam int PAD_W = amcp_pkg::TDATA_W - amcp_pkg::AXIS_W - amcp_pkg::MOVE_W
                           - amcp_pkg::POS_W - amcp_pkg::SPEED_W;

    logic [amcp_pkg::POS_W-1:0]     pos_reg [amcp_pkg::NUM_POS_REGS];
    logic                           m_valid_reg;
    logic [amcp_pkg::TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [amcp_pkg::STATUS_W-1:0]  m_user_reg;
    logic                           m_last_reg;

    logic [amcp_pkg::POS_W-1:0]     pos;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        clamped;
    logic [amcp_pkg::POS_W-1:0]     target;

    assign evt_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign m_user    = m_user_reg;
    assign m_last    = m_last_reg;

    assign pos = pos_reg[evt.axis];
    assign sum = signed'({{(SUM_W - amcp_pkg::POS_W){pos[amcp_pkg::POS_W-1]}}, pos})
               + signed'({evt.rel[amcp_pkg::MOVE_W-1], evt.rel});

    always_comb begin
        if (sum > LIM_HI) begin
            clamped = LIM_HI;
        end else if (sum < LIM_LO) begin
            clamped = LIM_LO;
        end else begin
            clamped = sum;
        end
        target = (evt.status == amcp_pkg::ST_CMD) ? clamped[amcp_pkg::POS_W-1:0] : '0;
        m_data_next = {{PAD_W{1'b0}}, evt.speed, target, evt.rel, evt.axis};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < amcp_pkg::NUM_POS_REGS; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en && int'(cfg_addr) < amcp_pkg::NUM_POS_REGS) begin
                pos_reg[cfg_addr] <= cfg_wr_data;
            end
            if (evt_ready) begin
                m_valid_reg <= evt_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_ready && evt_valid) begin
            m_data_reg <= m_data_next;
            m_user_reg <= evt.status;
            m_last_reg <= evt.last;
        end
    end

endmodule

// ===== design/axis_move_command_parser_unit.sv =====
// Path: a byte's result is registered in the parser's event register, then in
// the output register. Throughput: one byte per cycle while m_axis_tready does
// not back-pressure the output; the parser state register and the output
// register each advance once per transfer, with no stall of their own.
// Reset (aresetn low at a clock edge): parser back to expecting an axis letter,
// accumulators, per-axis memories and position registers cleared, no result held.
module axis_move_command_parser_unit #(
    parameter int NUM_AXES = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // data_byte
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // axis[2:0], relative_move[18:3], target[28:19], speed[36:29], zero[39:37]
    output logic [amcp_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [amcp_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
    output logic                                m_axis_tlast,  // packet_end
    input  logic                                cfg_wr_en,
    input  logic [amcp_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [amcp_pkg::POS_W-1:0]          cfg_wr_data
);

    logic           evt_valid;
    logic           evt_ready;
    amcp_pkg::evt_t evt;

    amcp_parser #(
        .NUM_AXES (NUM_AXES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .evt_ready (evt_ready),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    amcp_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .evt_valid   (evt_valid),
        .evt         (evt),
        .evt_ready   (evt_ready),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata),
        .m_user      (m_axis_tuser),
        .m_last      (m_axis_tlast)
    );

endmodule
